>>> hw/rtl/cfe_pkg.sv
// Shared types, constants and CRC helper for the CRC-32 frame encoder.
package cfe_pkg;

  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam int          HeaderLen  = 18;
  localparam int          TrailerLen = 4;
  localparam int          QueueDepth = 4;

  localparam logic [7:0] MagicR = 8'h52;
  localparam logic [7:0] MagicS = 8'h53;
  localparam logic [7:0] MagicV = 8'h56;
  localparam logic [7:0] Magic2 = 8'h32;

  localparam logic OpHeader  = 1'b0;
  localparam logic OpPayload = 1'b1;

  localparam logic CfgVersion    = 1'b0;
  localparam logic CfgMaxPayload = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_PAYLOAD,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        trailer;
    logic [7:0]  frame_type;
    logic [31:0] request_id;
    logic [31:0] sequence_number;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
  } cmd_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cfe_front.sv
// Front end: accepts input words, tracks frame state and issues commands.
module cfe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic          operation_i,
  input  logic [7:0]    frame_type_i,
  input  logic [31:0]   request_id_i,
  input  logic [31:0]   sequence_number_i,
  input  logic [31:0]   payload_length_i,
  input  logic [7:0]    payload_byte_i,
  input  logic [31:0]   max_payload_i,
  output logic          push_o,
  output cfe_pkg::cmd_t cmd_o
);

  logic        in_frame_q, in_frame_d;
  logic [31:0] remain_q, remain_d;

  assign push_o = in_valid_i && in_ready_i;

  always_comb begin
    in_frame_d            = in_frame_q;
    remain_d              = remain_q;
    cmd_o.kind            = cfe_pkg::CMD_ERROR;
    cmd_o.trailer         = 1'b0;
    cmd_o.frame_type      = frame_type_i;
    cmd_o.request_id      = request_id_i;
    cmd_o.sequence_number = sequence_number_i;
    cmd_o.payload_length  = payload_length_i;
    cmd_o.payload_byte    = payload_byte_i;
    if (operation_i == cfe_pkg::OpHeader) begin
      if (payload_length_i > max_payload_i) begin
        in_frame_d = 1'b0;
        remain_d   = 32'd0;
      end else begin
        cmd_o.kind    = cfe_pkg::CMD_HEADER;
        cmd_o.trailer = (payload_length_i == 32'd0);
        in_frame_d    = (payload_length_i != 32'd0);
        remain_d      = payload_length_i;
      end
    end else if (in_frame_q) begin
      cmd_o.kind    = cfe_pkg::CMD_PAYLOAD;
      cmd_o.trailer = (remain_q == 32'd1);
      in_frame_d    = (remain_q != 32'd1);
      remain_d      = remain_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      remain_q   <= 32'd0;
    end else if (push_o) begin
      in_frame_q <= in_frame_d;
      remain_q   <= remain_d;
    end
  end

endmodule

>>> hw/rtl/cfe_queue.sv
// Command queue between the front end and the byte generator.
module cfe_queue #(
  parameter int Depth = cfe_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfe_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cfe_pkg::cmd_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cfe_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/cfe_back.sv
// Back end: expands commands into output bytes and runs the CRC.
module cfe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cfe_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic [7:0]    version_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_error_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        last_q, error_q;

  logic        advance, is_hdr, is_err, hashed, in_trailer, is_last;
  logic [4:0]  tr_start, last_pos;
  logic [1:0]  tr_idx, sub_idx;
  logic [31:0] word_sel, crc_inv;
  logic [7:0]  byte_d;

  assign advance   = cmd_valid_i && (!valid_q || out_ready_i);
  assign is_hdr    = (cmd_i.kind == cfe_pkg::CMD_HEADER);
  assign is_err    = (cmd_i.kind == cfe_pkg::CMD_ERROR);
  assign tr_start  = is_hdr ? 5'(cfe_pkg::HeaderLen) : 5'd1;
  assign last_pos  = is_err ? 5'd0 :
                     cmd_i.trailer ? tr_start + 5'(cfe_pkg::TrailerLen - 1) :
                     tr_start - 5'd1;
  assign is_last   = (cnt_q == last_pos);
  assign in_trailer = !is_err && (cnt_q >= tr_start);
  assign tr_idx    = 2'(cnt_q - tr_start);
  assign sub_idx   = 2'(cnt_q - 5'd6);
  assign crc_inv   = ~crc_q;
  assign word_sel  = (cnt_q < 5'd10) ? cmd_i.request_id :
                     (cnt_q < 5'd14) ? cmd_i.sequence_number : cmd_i.payload_length;
  assign hashed    = !in_trailer && (is_hdr ? (cnt_q >= 5'd4) :
                                     (cmd_i.kind == cfe_pkg::CMD_PAYLOAD));
  assign cmd_pop_o = advance && is_last;

  always_comb begin
    byte_d = 8'd0;
    if (in_trailer) begin
      byte_d = crc_inv[8*tr_idx +: 8];
    end else if (is_hdr) begin
      case (cnt_q)
        5'd0:    byte_d = cfe_pkg::MagicR;
        5'd1:    byte_d = cfe_pkg::MagicS;
        5'd2:    byte_d = cfe_pkg::MagicV;
        5'd3:    byte_d = cfe_pkg::Magic2;
        5'd4:    byte_d = version_i;
        5'd5:    byte_d = cmd_i.frame_type;
        default: byte_d = word_sel[8*sub_idx +: 8];
      endcase
    end else if (!is_err) begin
      byte_d = cmd_i.payload_byte;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    if (advance) begin
      cnt_d = is_last ? 5'd0 : cnt_q + 5'd1;
      if (is_err || (is_hdr && cnt_q == 5'd0) || (in_trailer && is_last)) begin
        crc_d = cfe_pkg::CrcInit;
      end else if (hashed) begin
        crc_d = cfe_pkg::crc_feed(crc_q, byte_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 5'd0;
      crc_q   <= cfe_pkg::CrcInit;
      valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      if (advance) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= byte_d;
      last_q  <= is_last;
      error_q <= is_err;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_error_o = error_q;

endmodule

>>> hw/rtl/crc32_frame_encoder.sv
// CRC-32 length-prefixed frame encoder: config registers, front end, queue, back end.
// An accepted word passes the command queue and then the back end output register.
// Throughput: one output word per cycle while the output is not stalled; a payload
// word yields 1 output word (5 with trailer), a header 18 (22 with it), an error 1.
// Input is taken while the command queue has room. Reset (rst_ni, async) empties the
// queue, leaves the block idle outside any frame, version 1 and maximum payload 4096.
module crc32_frame_encoder #(
  parameter int QueueDepth = cfe_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_type[7:0], request_id[39:8], sequence_number[71:40],
  // payload_length[103:72], payload_byte[111:104]
  input  logic [111:0] s_axis_tdata,
  // operation[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  // error[0]
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [7:0]    version_q;
  logic [31:0]   max_payload_q;
  logic          push, q_full, cmd_valid, cmd_pop;
  cfe_pkg::cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q     <= 8'd1;
      max_payload_q <= 32'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfe_pkg::CfgVersion:    version_q     <= cfg_data_i[7:0];
        cfe_pkg::CfgMaxPayload: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;

  cfe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_i        (s_axis_tready),
    .operation_i       (s_axis_tuser),
    .frame_type_i      (s_axis_tdata[7:0]),
    .request_id_i      (s_axis_tdata[39:8]),
    .sequence_number_i (s_axis_tdata[71:40]),
    .payload_length_i  (s_axis_tdata[103:72]),
    .payload_byte_i    (s_axis_tdata[111:104]),
    .max_payload_i     (max_payload_q),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  cfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (head_cmd)
  );

  cfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .version_i   (version_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_error_o (m_axis_tuser)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error word without last or with data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_valid && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("accepted word did not reach the output in two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

endmodule
